[hw/rtl/first_fit_page_allocator_assert.svh]
// Assertion macros for the allocator RTL.
// Each macro expects clk and arst_n in scope.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define FFPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define FFPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ffpa_pkg.sv]
`default_nettype none
package ffpa_pkg;

	// Fixed field widths
	localparam int ADDR_W      = 32;
	localparam int COUNT_W     = 11;
	localparam int USABLE_W    = 11;
	localparam int STATUS_W    = 2;
	localparam int DESC_W      = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 32;

	// Parameter defaults
	localparam int DEFAULT_MAX_PAGES  = 1024;
	localparam int DEFAULT_PAGE_SHIFT = 12;

	// Register reset values
	localparam logic [ADDR_W-1:0]   ALLOC_BASE_RESET   = '0;
	localparam logic [USABLE_W-1:0] USABLE_PAGES_RESET = 11'd1024;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALLOC_BASE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USABLE_PAGES = 1'd1;

	// Operations
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;

	// Descriptor bits
	localparam int DESC_USED_BIT = 0;
	localparam int DESC_LAST_BIT = 1;
	localparam logic [DESC_W-1:0] DESC_FREE = 2'b00;
	localparam logic [DESC_W-1:0] DESC_USED = 2'b01;
	localparam logic [DESC_W-1:0] DESC_TAIL = 2'b11;

	// Microprogram addresses
	localparam int UPC_W = 4;
	localparam logic [UPC_W-1:0] S_CLR      = 4'd0;
	localparam logic [UPC_W-1:0] S_IDLE     = 4'd1;
	localparam logic [UPC_W-1:0] S_DISPATCH = 4'd2;
	localparam logic [UPC_W-1:0] S_ACHK     = 4'd3;
	localparam logic [UPC_W-1:0] S_SCAN     = 4'd4;
	localparam logic [UPC_W-1:0] S_SCANEND  = 4'd5;
	localparam logic [UPC_W-1:0] S_NOSPACE  = 4'd6;
	localparam logic [UPC_W-1:0] S_MARK     = 4'd7;
	localparam logic [UPC_W-1:0] S_FCHK     = 4'd8;
	localparam logic [UPC_W-1:0] S_FREAD    = 4'd9;
	localparam logic [UPC_W-1:0] S_FWALK    = 4'd10;
	localparam logic [UPC_W-1:0] S_FREED    = 4'd11;
	localparam logic [UPC_W-1:0] S_BADADDR  = 4'd12;
	localparam logic [UPC_W-1:0] S_RESULT   = 4'd13;

	// Datapath actions
	localparam int ACT_W = 4;
	localparam logic [ACT_W-1:0] ACT_NOP         = 4'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR       = 4'd1;
	localparam logic [ACT_W-1:0] ACT_TAKE        = 4'd2;
	localparam logic [ACT_W-1:0] ACT_ACHK        = 4'd3;
	localparam logic [ACT_W-1:0] ACT_SCAN        = 4'd4;
	localparam logic [ACT_W-1:0] ACT_ADDR        = 4'd5;
	localparam logic [ACT_W-1:0] ACT_MARK        = 4'd6;
	localparam logic [ACT_W-1:0] ACT_FCHK        = 4'd7;
	localparam logic [ACT_W-1:0] ACT_FREAD       = 4'd8;
	localparam logic [ACT_W-1:0] ACT_FWALK       = 4'd9;
	localparam logic [ACT_W-1:0] ACT_SET_NOSPACE = 4'd10;
	localparam logic [ACT_W-1:0] ACT_SET_BADADDR = 4'd11;
	localparam logic [ACT_W-1:0] ACT_SET_FREED   = 4'd12;
	localparam logic [ACT_W-1:0] ACT_EMIT        = 4'd13;

	// Jump conditions
	localparam int COND_W = 4;
	localparam logic [COND_W-1:0] COND_ALWAYS     = 4'd0;
	localparam logic [COND_W-1:0] COND_NEVER      = 4'd1;
	localparam logic [COND_W-1:0] COND_IN_TAKEN   = 4'd2;
	localparam logic [COND_W-1:0] COND_OP_FREE    = 4'd3;
	localparam logic [COND_W-1:0] COND_ALLOC_BAD  = 4'd4;
	localparam logic [COND_W-1:0] COND_SCAN_DONE  = 4'd5;
	localparam logic [COND_W-1:0] COND_FOUND      = 4'd6;
	localparam logic [COND_W-1:0] COND_MARK_DONE  = 4'd7;
	localparam logic [COND_W-1:0] COND_ADDR_BAD   = 4'd8;
	localparam logic [COND_W-1:0] COND_WALK_DONE  = 4'd9;
	localparam logic [COND_W-1:0] COND_CLEAR_DONE = 4'd10;
	localparam logic [COND_W-1:0] COND_OUT_FREE   = 4'd11;

	// One control word: action, jump condition, jump target, hold when not taken
	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [COND_W-1:0] cond;
		logic [UPC_W-1:0]  target;
		logic              hold;
	} ctrl_t;

	// Status flags from the datapath to the sequencer
	typedef struct packed {
		logic in_taken;
		logic op_free;
		logic alloc_bad;
		logic scan_done;
		logic found;
		logic mark_done;
		logic addr_bad;
		logic walk_done;
		logic clear_done;
		logic out_free;
	} flags_t;

endpackage
`default_nettype wire

[hw/rtl/ffpa_ram.sv]
`default_nettype none
module ffpa_ram #(
	parameter int WIDTH = ffpa_pkg::DESC_W,
	parameter int DEPTH = ffpa_pkg::DEFAULT_MAX_PAGES
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hw/rtl/ffpa_useq.sv]
`default_nettype none
module ffpa_useq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  var  ffpa_pkg::flags_t flags,
	output ffpa_pkg::ctrl_t       ctrl
);

	logic [ffpa_pkg::UPC_W-1:0] upc_q;
	logic [ffpa_pkg::UPC_W-1:0] upc_next;
	logic                       cond_met;

	// Microprogram: action, condition, target, hold
	function automatic ffpa_pkg::ctrl_t rom_word(input logic [ffpa_pkg::UPC_W-1:0] upc);
		ffpa_pkg::ctrl_t w;
		case (upc)
			ffpa_pkg::S_CLR: w = '{ffpa_pkg::ACT_CLEAR, ffpa_pkg::COND_CLEAR_DONE,
				ffpa_pkg::S_IDLE, 1'b1};
			ffpa_pkg::S_IDLE: w = '{ffpa_pkg::ACT_TAKE, ffpa_pkg::COND_IN_TAKEN,
				ffpa_pkg::S_DISPATCH, 1'b1};
			ffpa_pkg::S_DISPATCH: w = '{ffpa_pkg::ACT_NOP, ffpa_pkg::COND_OP_FREE,
				ffpa_pkg::S_FCHK, 1'b0};
			ffpa_pkg::S_ACHK: w = '{ffpa_pkg::ACT_ACHK, ffpa_pkg::COND_ALLOC_BAD,
				ffpa_pkg::S_NOSPACE, 1'b0};
			ffpa_pkg::S_SCAN: w = '{ffpa_pkg::ACT_SCAN, ffpa_pkg::COND_SCAN_DONE,
				ffpa_pkg::S_SCANEND, 1'b1};
			ffpa_pkg::S_SCANEND: w = '{ffpa_pkg::ACT_ADDR, ffpa_pkg::COND_FOUND,
				ffpa_pkg::S_MARK, 1'b0};
			ffpa_pkg::S_NOSPACE: w = '{ffpa_pkg::ACT_SET_NOSPACE, ffpa_pkg::COND_ALWAYS,
				ffpa_pkg::S_RESULT, 1'b0};
			ffpa_pkg::S_MARK: w = '{ffpa_pkg::ACT_MARK, ffpa_pkg::COND_MARK_DONE,
				ffpa_pkg::S_RESULT, 1'b1};
			ffpa_pkg::S_FCHK: w = '{ffpa_pkg::ACT_FCHK, ffpa_pkg::COND_ADDR_BAD,
				ffpa_pkg::S_BADADDR, 1'b0};
			ffpa_pkg::S_FREAD: w = '{ffpa_pkg::ACT_FREAD, ffpa_pkg::COND_NEVER,
				ffpa_pkg::S_FREAD, 1'b0};
			ffpa_pkg::S_FWALK: w = '{ffpa_pkg::ACT_FWALK, ffpa_pkg::COND_WALK_DONE,
				ffpa_pkg::S_FREED, 1'b1};
			ffpa_pkg::S_FREED: w = '{ffpa_pkg::ACT_SET_FREED, ffpa_pkg::COND_ALWAYS,
				ffpa_pkg::S_RESULT, 1'b0};
			ffpa_pkg::S_BADADDR: w = '{ffpa_pkg::ACT_SET_BADADDR, ffpa_pkg::COND_ALWAYS,
				ffpa_pkg::S_RESULT, 1'b0};
			ffpa_pkg::S_RESULT: w = '{ffpa_pkg::ACT_EMIT, ffpa_pkg::COND_OUT_FREE,
				ffpa_pkg::S_IDLE, 1'b1};
			default: w = '{ffpa_pkg::ACT_NOP, ffpa_pkg::COND_ALWAYS,
				ffpa_pkg::S_IDLE, 1'b0};
		endcase
		return w;
	endfunction

	assign ctrl = rom_word(upc_q);

	// Select the jump condition
	always_comb begin
		case (ctrl.cond)
			ffpa_pkg::COND_ALWAYS:     cond_met = 1'b1;
			ffpa_pkg::COND_NEVER:      cond_met = 1'b0;
			ffpa_pkg::COND_IN_TAKEN:   cond_met = flags.in_taken;
			ffpa_pkg::COND_OP_FREE:    cond_met = flags.op_free;
			ffpa_pkg::COND_ALLOC_BAD:  cond_met = flags.alloc_bad;
			ffpa_pkg::COND_SCAN_DONE:  cond_met = flags.scan_done;
			ffpa_pkg::COND_FOUND:      cond_met = flags.found;
			ffpa_pkg::COND_MARK_DONE:  cond_met = flags.mark_done;
			ffpa_pkg::COND_ADDR_BAD:   cond_met = flags.addr_bad;
			ffpa_pkg::COND_WALK_DONE:  cond_met = flags.walk_done;
			ffpa_pkg::COND_CLEAR_DONE: cond_met = flags.clear_done;
			ffpa_pkg::COND_OUT_FREE:   cond_met = flags.out_free;
			default:                   cond_met = 1'b0;
		endcase
	end

	// Jump, hold or advance
	always_comb begin
		if (cond_met) begin
			upc_next = ctrl.target;
		end else if (ctrl.hold) begin
			upc_next = upc_q;
		end else begin
			upc_next = upc_q + ffpa_pkg::UPC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ffpa_pkg::S_CLR;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/ffpa_dpath.sv]
`default_nettype none
`include "first_fit_page_allocator_assert.svh"
module ffpa_dpath #(
	parameter int MAX_PAGES  = ffpa_pkg::DEFAULT_MAX_PAGES,
	parameter int PAGE_SHIFT = ffpa_pkg::DEFAULT_PAGE_SHIFT
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  var  ffpa_pkg::ctrl_t                       ctrl,
	output ffpa_pkg::flags_t                           flags,
	input  wire logic [ffpa_pkg::ADDR_W-1:0]           alloc_base,
	input  wire logic [ffpa_pkg::USABLE_W-1:0]         usable_pages,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [ffpa_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  wire logic                                  s_tuser,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic      [ffpa_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic      [ffpa_pkg::STATUS_W-1:0]         m_tuser,
	output logic                                       ram_we,
	output logic      [$clog2(MAX_PAGES)-1:0]          ram_waddr,
	output logic      [ffpa_pkg::DESC_W-1:0]           ram_wdata,
	output logic      [$clog2(MAX_PAGES)-1:0]          ram_raddr,
	input  wire logic [ffpa_pkg::DESC_W-1:0]           ram_rdata
);

	localparam int IDX_W = $clog2(MAX_PAGES);
	localparam int CNT_W = $clog2(MAX_PAGES + 1);
	localparam int CMP_W = (CNT_W > ffpa_pkg::COUNT_W) ? CNT_W : ffpa_pkg::COUNT_W;
	localparam int OFF_W = IDX_W + PAGE_SHIFT;
	localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(MAX_PAGES - 1);

	// Request registers
	logic                            op_q;
	logic [ffpa_pkg::COUNT_W-1:0]    count_q;
	logic [ffpa_pkg::ADDR_W-1:0]     faddr_q;

	// Walk registers
	logic [IDX_W-1:0]                j_q;
	logic [IDX_W-1:0]                k_q;
	logic [CNT_W-1:0]                run_q;
	logic                            found_q;
	logic [ffpa_pkg::ADDR_W-1:0]     addr_q;
	logic [ffpa_pkg::STATUS_W-1:0]   st_q;

	// Output register
	logic                            m_valid_q;
	logic [ffpa_pkg::ADDR_W-1:0]     m_addr_q;
	logic [ffpa_pkg::STATUS_W-1:0]   m_status_q;

	logic [CMP_W-1:0]                n_w;
	logic [CMP_W-1:0]                usable_w;
	logic [CMP_W-1:0]                count_w;
	logic [CMP_W-1:0]                j_w;
	logic [CNT_W-1:0]                run_next;
	logic                            desc_busy;
	logic                            found_now;
	logic                            at_end;
	logic [CMP_W-1:0]                start_w;
	logic [OFF_W-1:0]                page_off;
	logic [ffpa_pkg::ADDR_W-1:0]     alloc_addr;
	logic [ffpa_pkg::ADDR_W-1:0]     addr_diff;
	logic [ffpa_pkg::ADDR_W-1:0]     idx_full;
	logic                            out_free;
	logic                            emit;

	// Clamp the usable count to the table depth
	assign usable_w = CMP_W'(usable_pages);
	assign n_w      = (usable_w > CMP_W'(MAX_PAGES)) ? CMP_W'(MAX_PAGES) : usable_w;
	assign count_w  = CMP_W'(count_q);
	assign j_w      = CMP_W'(j_q);

	// Scan step: extend or reset the free run
	assign desc_busy = ram_rdata[ffpa_pkg::DESC_USED_BIT];
	assign run_next  = desc_busy ? '0 : run_q + CNT_W'(1);
	assign found_now = !desc_busy && (CMP_W'(run_next) == count_w);
	assign at_end    = (j_w == n_w - CMP_W'(1));
	assign start_w   = j_w + CMP_W'(1) - count_w;

	// Page address of the run start
	assign page_off   = {k_q, {PAGE_SHIFT{1'b0}}};
	assign alloc_addr = alloc_base + ffpa_pkg::ADDR_W'(page_off);

	// Free address range check
	assign addr_diff = faddr_q - alloc_base;
	assign idx_full  = addr_diff >> PAGE_SHIFT;

	assign out_free = !m_valid_q || m_tready;
	assign emit     = (ctrl.act == ffpa_pkg::ACT_EMIT) && out_free;
	assign s_tready = (ctrl.act == ffpa_pkg::ACT_TAKE);

	// Flags to the sequencer
	always_comb begin
		flags.in_taken   = s_tvalid && s_tready;
		flags.op_free    = (op_q == ffpa_pkg::OP_FREE);
		flags.alloc_bad  = (count_q == '0) || (count_w > n_w);
		flags.scan_done  = found_now || at_end;
		flags.found      = found_q;
		flags.mark_done  = (k_q == j_q);
		flags.addr_bad   = (faddr_q < alloc_base) ||
			(idx_full >= ffpa_pkg::ADDR_W'(n_w));
		flags.walk_done  = ram_rdata[ffpa_pkg::DESC_LAST_BIT] || (k_q == TOP_IDX);
		flags.clear_done = (k_q == TOP_IDX);
		flags.out_free   = out_free;
	end

	// Descriptor store access
	always_comb begin
		ram_we    = (ctrl.act == ffpa_pkg::ACT_CLEAR) || (ctrl.act == ffpa_pkg::ACT_MARK) ||
			(ctrl.act == ffpa_pkg::ACT_FWALK);
		ram_waddr = k_q;
		if (ctrl.act == ffpa_pkg::ACT_MARK) begin
			ram_wdata = (k_q == j_q) ? ffpa_pkg::DESC_TAIL : ffpa_pkg::DESC_USED;
		end else begin
			ram_wdata = ffpa_pkg::DESC_FREE;
		end
		case (ctrl.act)
			ffpa_pkg::ACT_ACHK:  ram_raddr = '0;
			ffpa_pkg::ACT_SCAN:  ram_raddr = j_q + IDX_W'(1);
			ffpa_pkg::ACT_FWALK: ram_raddr = k_q + IDX_W'(1);
			default:             ram_raddr = k_q;
		endcase
	end

	// Control registers: walk pointer, found mark, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			found_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			case (ctrl.act)
				ffpa_pkg::ACT_CLEAR: k_q <= k_q + IDX_W'(1);
				ffpa_pkg::ACT_ACHK:  found_q <= 1'b0;
				ffpa_pkg::ACT_SCAN: begin
					if (found_now) begin
						found_q <= 1'b1;
						k_q     <= start_w[IDX_W-1:0];
					end
				end
				ffpa_pkg::ACT_MARK:  k_q <= k_q + IDX_W'(1);
				ffpa_pkg::ACT_FCHK:  k_q <= idx_full[IDX_W-1:0];
				ffpa_pkg::ACT_FWALK: k_q <= k_q + IDX_W'(1);
				default: ;
			endcase
			// Drop the result once taken, load a new one on emit
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (ctrl.act)
			ffpa_pkg::ACT_TAKE: begin
				if (s_tvalid) begin
					op_q    <= s_tuser;
					count_q <= s_tdata[ffpa_pkg::COUNT_W-1:0];
					faddr_q <= s_tdata[ffpa_pkg::COUNT_W +: ffpa_pkg::ADDR_W];
				end
			end
			ffpa_pkg::ACT_ACHK: begin
				j_q   <= '0;
				run_q <= '0;
			end
			ffpa_pkg::ACT_SCAN: begin
				if (!(found_now || at_end)) begin
					j_q   <= j_q + IDX_W'(1);
					run_q <= run_next;
				end
			end
			ffpa_pkg::ACT_ADDR: begin
				addr_q <= alloc_addr;
				st_q   <= ffpa_pkg::ST_OK;
			end
			ffpa_pkg::ACT_SET_NOSPACE: begin
				addr_q <= '0;
				st_q   <= ffpa_pkg::ST_NO_SPACE;
			end
			ffpa_pkg::ACT_SET_BADADDR: begin
				addr_q <= '0;
				st_q   <= ffpa_pkg::ST_BAD_ADDR;
			end
			ffpa_pkg::ACT_SET_FREED: begin
				addr_q <= '0;
				st_q   <= ffpa_pkg::ST_OK;
			end
			default: ;
		endcase
		if (emit) begin
			m_addr_q   <= addr_q;
			m_status_q <= st_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_addr_q;
	assign m_tuser  = m_status_q;

	`FFPA_ASSERT_NOW(a_run_fits, (ctrl.act == ffpa_pkg::ACT_SCAN) && found_now,
		j_w + CMP_W'(1) >= count_w, "found run starts before page zero")
	`FFPA_ASSERT_NOW(a_fail_addr_zero, m_valid_q && (m_status_q != ffpa_pkg::ST_OK),
		m_addr_q == '0, "failed result carries an address")
	`FFPA_ASSERT_NEXT(a_emit_loads, emit, m_valid_q, "emitted result not held")
	`FFPA_ASSERT_NOW(a_write_steps, ram_we,
		(ctrl.act == ffpa_pkg::ACT_CLEAR) || (ctrl.act == ffpa_pkg::ACT_MARK) ||
		(ctrl.act == ffpa_pkg::ACT_FWALK), "descriptor write outside a write step")

endmodule
`default_nettype wire

[hw/rtl/first_fit_page_allocator.sv]
// Allocate: check the count, find the first free run of that size, mark it, return its address;
// no run found, or a zero or oversized count, returns no space. Free: check the address and
// clear its run; an address out of range returns bad address. The scan reads one descriptor
// a cycle. One request is in work at a time; the next is taken in the cycle after the
// result loads, and a result held by m_tready low stalls the sequencer at its next result
// until taken. Reset clears the descriptor RAM with s_tready low; config writes always.
`default_nettype none
module first_fit_page_allocator #(
	parameter int MAX_PAGES  = ffpa_pkg::DEFAULT_MAX_PAGES,
	parameter int PAGE_SHIFT = ffpa_pkg::DEFAULT_PAGE_SHIFT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Request stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [ffpa_pkg::IN_TDATA_W-1:0]     s_tdata,  // page_count, free_address, pad
	input  wire logic                                s_tuser,  // operation
	// Result stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [ffpa_pkg::OUT_TDATA_W-1:0]    m_tdata,  // address
	output logic      [ffpa_pkg::STATUS_W-1:0]       m_tuser,  // status
	// Register writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ffpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ffpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IDX_W = $clog2(MAX_PAGES);

	logic [ffpa_pkg::ADDR_W-1:0]   alloc_base_q;
	logic [ffpa_pkg::USABLE_W-1:0] usable_pages_q;
	ffpa_pkg::ctrl_t               ctrl;
	ffpa_pkg::flags_t              flags;
	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	logic [ffpa_pkg::DESC_W-1:0]   ram_wdata;
	logic [IDX_W-1:0]              ram_raddr;
	logic [ffpa_pkg::DESC_W-1:0]   ram_rdata;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_base_q   <= ffpa_pkg::ALLOC_BASE_RESET;
			usable_pages_q <= ffpa_pkg::USABLE_PAGES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ffpa_pkg::REG_ALLOC_BASE:   alloc_base_q   <= cfg_data[ffpa_pkg::ADDR_W-1:0];
				ffpa_pkg::REG_USABLE_PAGES: usable_pages_q <= cfg_data[ffpa_pkg::USABLE_W-1:0];
				default: ;
			endcase
		end
	end

	ffpa_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	ffpa_dpath #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.flags        (flags),
		.alloc_base   (alloc_base_q),
		.usable_pages (usable_pages_q),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	ffpa_ram #(
		.WIDTH (ffpa_pkg::DESC_W),
		.DEPTH (MAX_PAGES)
	) u_desc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire
